// ----- rtl/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LENGTH  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_MARGIN = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM          = 8'd4;

    localparam logic [31:0] RST_HEAP_BASE    = 32'd0;
    localparam logic [31:0] RST_HEAP_LENGTH  = 32'd65536;
    localparam logic [7:0]  RST_HEADER_BYTES = 8'd16;
    localparam logic [15:0] RST_SPLIT_MARGIN = 16'd16;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OOM       = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam int UNIT_W = 34;

    typedef enum logic {
        OP_ADD,
        OP_SUB
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [UNIT_W-1:0] a;
        logic [UNIT_W-1:0] b;
        logic [UNIT_W-1:0] c;
        logic [UNIT_W-1:0] x;
        logic [UNIT_W-1:0] y;
    } t_unit_req;

    typedef struct packed {
        logic [UNIT_W:0] sum;
        logic            ge;
    } t_unit_res;

endpackage

// ----- rtl/ffba_unit.sv -----
// ----------------------------------------------------------------------------
// ffba_unit
// Shared three-operand adder/subtractor and magnitude comparator.
// ----------------------------------------------------------------------------
module ffba_unit (
    input  ffba_pkg::t_unit_req i_req,
    output ffba_pkg::t_unit_res o_res
);
    import ffba_pkg::*;

    logic [UNIT_W:0] w_a;
    logic [UNIT_W:0] w_b;
    logic [UNIT_W:0] w_c;

    assign w_a = {1'b0, i_req.a};
    assign w_b = {1'b0, i_req.b};
    assign w_c = {1'b0, i_req.c};

    always_comb begin
        case (i_req.op)
            OP_ADD:  o_res.sum = w_a + w_b + w_c;
            OP_SUB:  o_res.sum = w_a - w_b - w_c;
            default: o_res.sum = w_a + w_b + w_c;
        endcase
        o_res.ge = (i_req.x >= i_req.y);
    end

endmodule

// ----- rtl/first_fit_block_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit heap allocator with segment splitting and free-list coalescing.
// ----------------------------------------------------------------------------
// Requests arrive on i_valid/o_ready and carry a request type with its size,
// alignment and address; each request yields exactly one response on
// o_valid/i_ready holding a pointer and a status. An allocate request runs
// the set-up states S_NEED, S_THR and S_MASK, walks the segments in order
// in S_FIT, decides on a split in S_SPLIT_CHK, splits through S_SPLIT_A and
// S_SPLIT_B when it splits, forms the pointer in S_PTR and loads the
// response in S_RESP; when none of the segments fits, the walk ends in S_RESP.
// A free request walks the table through S_FLO, S_FHI and S_FCHK for each
// segment (two adds and a bound check through the single shared
// adder/comparator), then runs one coalescing step per cycle in S_MERGE.
// Every address sum and every size compare of a request goes through the
// shared unit in ffba_unit.
// Only one request is in flight; o_ready is high whenever the sequencer is
// idle, even while a previous response still waits for i_ready, since the
// response sits in its own output register. A stalled receiver holds the
// sequencer in its response state until the register frees up.
// Reset, and any configuration write to a listed register, restores the
// default configuration or applies the written value and rebuilds the table
// as one free segment covering the whole heap. Writes are to be made only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit #(
    parameter int MAX_SEGMENTS = ffba_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ffba_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_req_type,
    input  logic [31:0]                    i_request_size,
    input  logic [31:0]                    i_align_bytes,
    input  logic [31:0]                    i_free_address,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [31:0]                    o_result_address,
    output logic [1:0]                     o_status
);
    import ffba_pkg::*;

    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // Sequencer states: set-up, first-fit walk, split, pointer, free walk,
    // coalescing and response hand-over.
    typedef enum logic [3:0] {
        S_IDLE,
        S_NEED,
        S_THR,
        S_MASK,
        S_FIT,
        S_SPLIT_CHK,
        S_SPLIT_A,
        S_SPLIT_B,
        S_PTR,
        S_FLO,
        S_FHI,
        S_FCHK,
        S_MERGE,
        S_RESP
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [31:0] r_heap_base;
    logic [31:0] r_heap_length;
    logic [7:0]  r_header_bytes;
    logic [15:0] r_split_margin;

    logic [31:0] n_heap_base;
    logic [31:0] n_heap_length;
    logic [7:0]  n_header_bytes;
    logic [15:0] n_split_margin;
    logic [31:0] n_first_size;
    logic        w_cfg_hit;

    // Segment table, kept in address order.
    logic [31:0]      r_seg_start [MAX_SEGMENTS];
    logic [31:0]      r_seg_size  [MAX_SEGMENTS];
    logic             r_seg_used  [MAX_SEGMENTS];
    logic [CNT_W-1:0] r_count;

    // Captured request and working registers.
    logic [31:0]      r_req_size;
    logic [31:0]      r_align;
    logic [31:0]      r_addr;
    logic [32:0]      r_need;
    logic [33:0]      r_thr;
    logic [31:0]      r_mask;
    logic [31:0]      r_tmp;
    logic [32:0]      r_hi;
    logic             r_ge_lo;
    logic             r_found;
    logic [CNT_W-1:0] r_idx;
    logic [31:0]      r_res_addr;
    logic [1:0]       r_res_status;
    logic             r_out_valid;
    logic [31:0]      r_out_addr;
    logic [1:0]       r_out_status;

    logic [CNT_W-1:0] w_idx1;
    logic [IDX_W-1:0] w_sel;
    logic [IDX_W-1:0] w_sel1;
    logic [31:0]      w_start_i;
    logic [31:0]      w_size_i;
    logic             w_used_i;
    logic [31:0]      w_size_i1;
    logic             w_used_i1;
    logic [31:0]      w_merged;

    t_unit_req w_ureq;
    t_unit_res w_ures;

    assign w_idx1    = r_idx + CNT_ONE;
    assign w_sel     = r_idx[IDX_W-1:0];
    assign w_sel1    = w_idx1[IDX_W-1:0];
    assign w_start_i = r_seg_start[w_sel];
    assign w_size_i  = r_seg_size[w_sel];
    assign w_used_i  = r_seg_used[w_sel];
    assign w_size_i1 = r_seg_size[w_sel1];
    assign w_used_i1 = r_seg_used[w_sel1];

    // A merged segment saturates at the top of the 32-bit range.
    assign w_merged = (|w_ures.sum[UNIT_W:32]) ? 32'hFFFF_FFFF : w_ures.sum[31:0];

    // Next configuration values, so the table can be rebuilt in the same
    // cycle as the write.
    always_comb begin
        n_heap_base    = r_heap_base;
        n_heap_length  = r_heap_length;
        n_header_bytes = r_header_bytes;
        n_split_margin = r_split_margin;
        w_cfg_hit      = i_cfg_we && (i_cfg_index < CFG_NUM);
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEAP_BASE:    n_heap_base    = i_cfg_data[31:0];
                CFG_HEAP_LENGTH:  n_heap_length  = i_cfg_data[31:0];
                CFG_HEADER_BYTES: n_header_bytes = i_cfg_data[7:0];
                CFG_SPLIT_MARGIN: n_split_margin = i_cfg_data[15:0];
                default: ;
            endcase
        end
        n_first_size = (n_heap_length > {24'd0, n_header_bytes})
                     ? n_heap_length - {24'd0, n_header_bytes} : 32'd0;
    end

    // Operand selection for the shared unit.
    always_comb begin
        w_ureq    = '0;
        w_ureq.op = OP_ADD;
        case (r_state)
            S_NEED: begin
                w_ureq.a = UNIT_W'(r_req_size);
                w_ureq.b = UNIT_W'(r_align);
            end
            S_THR: begin
                w_ureq.a = UNIT_W'(r_need);
                w_ureq.b = UNIT_W'(r_header_bytes);
                w_ureq.c = UNIT_W'(r_split_margin);
            end
            S_MASK: begin
                w_ureq.op = OP_SUB;
                w_ureq.b  = UNIT_W'(r_align);
            end
            S_FIT: begin
                w_ureq.x = UNIT_W'(w_size_i);
                w_ureq.y = UNIT_W'(r_need);
            end
            S_SPLIT_CHK: begin
                w_ureq.x = UNIT_W'(r_thr);
                w_ureq.y = UNIT_W'(w_size_i);
            end
            S_SPLIT_A: begin
                w_ureq.a = UNIT_W'(w_start_i);
                w_ureq.b = UNIT_W'(r_header_bytes);
                w_ureq.c = UNIT_W'(r_need[31:0]);
            end
            S_SPLIT_B: begin
                w_ureq.op = OP_SUB;
                w_ureq.a  = UNIT_W'(w_size_i);
                w_ureq.b  = UNIT_W'(r_header_bytes);
                w_ureq.c  = UNIT_W'(r_need[31:0]);
            end
            S_PTR: begin
                w_ureq.a = UNIT_W'(w_start_i);
                w_ureq.b = UNIT_W'(r_header_bytes);
                w_ureq.c = UNIT_W'(r_align);
            end
            S_FLO: begin
                w_ureq.a = UNIT_W'(w_start_i);
                w_ureq.b = UNIT_W'(r_header_bytes);
            end
            S_FHI: begin
                w_ureq.a = UNIT_W'(r_tmp);
                w_ureq.b = UNIT_W'(w_size_i);
                w_ureq.x = UNIT_W'(r_addr);
                w_ureq.y = UNIT_W'(r_tmp);
            end
            S_FCHK: begin
                w_ureq.x = UNIT_W'(r_hi);
                w_ureq.y = UNIT_W'(r_addr);
            end
            S_MERGE: begin
                w_ureq.a = UNIT_W'(w_size_i);
                w_ureq.b = UNIT_W'(w_size_i1);
                w_ureq.c = UNIT_W'(r_header_bytes);
            end
            default: ;
        endcase
    end

    ffba_unit u_unit (
        .i_req (w_ureq),
        .o_res (w_ures)
    );

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_result_address = r_out_addr;
    assign o_status         = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_heap_base    <= RST_HEAP_BASE;
            r_heap_length  <= RST_HEAP_LENGTH;
            r_header_bytes <= RST_HEADER_BYTES;
            r_split_margin <= RST_SPLIT_MARGIN;
            r_count        <= CNT_ONE;
            r_seg_start[0] <= RST_HEAP_BASE;
            r_seg_size[0]  <= RST_HEAP_LENGTH - {24'd0, RST_HEADER_BYTES};
            for (int k = 0; k < MAX_SEGMENTS; k++) begin
                r_seg_used[k] <= 1'b0;
            end
        end else begin
            // The response state reloads the output register itself.
            if (r_out_valid && i_ready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end

            if (w_cfg_hit) begin
                r_heap_base    <= n_heap_base;
                r_heap_length  <= n_heap_length;
                r_header_bytes <= n_header_bytes;
                r_split_margin <= n_split_margin;
                r_count        <= CNT_ONE;
                r_seg_start[0] <= n_heap_base;
                r_seg_size[0]  <= n_first_size;
                for (int k = 0; k < MAX_SEGMENTS; k++) begin
                    r_seg_used[k] <= 1'b0;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req_size <= i_request_size;
                        r_align    <= i_align_bytes;
                        r_addr     <= i_free_address;
                        r_idx      <= '0;
                        r_found    <= 1'b0;
                        r_state    <= (i_req_type == REQ_FREE) ? S_FLO : S_NEED;
                    end
                end
                S_NEED: begin
                    r_need  <= w_ures.sum[32:0];
                    r_state <= S_THR;
                end
                S_THR: begin
                    r_thr   <= w_ures.sum[33:0];
                    r_state <= S_MASK;
                end
                S_MASK: begin
                    r_mask  <= (r_align == 32'd0) ? 32'hFFFF_FFFF : w_ures.sum[31:0];
                    r_state <= S_FIT;
                end
                S_FIT: begin
                    if (r_idx >= r_count) begin
                        r_res_addr   <= 32'd0;
                        r_res_status <= ST_OOM;
                        r_state      <= S_RESP;
                    end else if (!w_used_i && w_ures.ge) begin
                        r_state <= S_SPLIT_CHK;
                    end else begin
                        r_idx <= w_idx1;
                    end
                end
                S_SPLIT_CHK: begin
                    // No split when the leftover is too small or the table is full.
                    if (w_ures.ge || (r_count >= CNT_MAX)) begin
                        r_state <= S_PTR;
                    end else begin
                        r_state <= S_SPLIT_A;
                    end
                end
                S_SPLIT_A: begin
                    r_tmp   <= w_ures.sum[31:0];
                    r_state <= S_SPLIT_B;
                end
                S_SPLIT_B: begin
                    for (int k = 1; k < MAX_SEGMENTS; k++) begin
                        if ((CNT_W'(k) > w_idx1) && (CNT_W'(k) <= r_count)) begin
                            r_seg_start[k] <= r_seg_start[k-1];
                            r_seg_size[k]  <= r_seg_size[k-1];
                            r_seg_used[k]  <= r_seg_used[k-1];
                        end
                    end
                    r_seg_start[w_sel1] <= r_tmp;
                    r_seg_size[w_sel1]  <= w_ures.sum[31:0];
                    r_seg_used[w_sel1]  <= 1'b0;
                    r_seg_size[w_sel]   <= r_need[31:0];
                    r_count             <= r_count + CNT_ONE;
                    r_state             <= S_PTR;
                end
                S_PTR: begin
                    r_seg_used[w_sel] <= 1'b1;
                    r_res_addr        <= w_ures.sum[31:0] & r_mask;
                    r_res_status      <= ST_OK;
                    r_state           <= S_RESP;
                end
                S_FLO: begin
                    r_tmp   <= w_ures.sum[31:0];
                    r_state <= S_FHI;
                end
                S_FHI: begin
                    r_hi    <= w_ures.sum[32:0];
                    r_ge_lo <= w_ures.ge;
                    r_state <= S_FCHK;
                end
                S_FCHK: begin
                    if (w_ures.ge && r_ge_lo) begin
                        r_seg_used[w_sel] <= 1'b0;
                        r_found           <= 1'b1;
                        r_idx             <= '0;
                        r_state           <= S_MERGE;
                    end else if (w_idx1 < r_count) begin
                        r_idx   <= w_idx1;
                        r_state <= S_FLO;
                    end else begin
                        r_idx   <= '0;
                        r_state <= S_MERGE;
                    end
                end
                S_MERGE: begin
                    if (w_idx1 < r_count) begin
                        if (!w_used_i && !w_used_i1) begin
                            r_seg_size[w_sel] <= w_merged;
                            for (int k = 1; k < MAX_SEGMENTS - 1; k++) begin
                                if ((CNT_W'(k) >= w_idx1) && (CNT_W'(k + 1) < r_count)) begin
                                    r_seg_start[k] <= r_seg_start[k+1];
                                    r_seg_size[k]  <= r_seg_size[k+1];
                                    r_seg_used[k]  <= r_seg_used[k+1];
                                end
                            end
                            r_count <= r_count - CNT_ONE;
                        end else begin
                            r_idx <= w_idx1;
                        end
                    end else begin
                        r_res_addr   <= 32'd0;
                        r_res_status <= r_found ? ST_OK : ST_NOT_FOUND;
                        r_state      <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_addr   <= r_res_addr;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The table always holds between one and MAX_SEGMENTS segments.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CNT_MAX))
        else $error("segment count out of range");

    // An accepted request keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("block ready straight after accepting a request");

    // Failed requests never return a pointer.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_result_address == 32'd0))
        else $error("non-zero pointer with a failure status");

    // A write to a listed register leaves a single segment.
    a_cfg_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_index < CFG_NUM)) |=> (r_count == CNT_ONE))
        else $error("table not rebuilt after a configuration write");

endmodule

// ----- verif/ffba_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_checker
// Watches the request, response and configuration ports of the allocator,
// keeps its own copy of the segment table and compares every response.
// ----------------------------------------------------------------------------
module ffba_checker #(
    parameter int MAX_SEGMENTS = ffba_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ffba_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    input  logic                            i_ready_in,
    input  logic                            i_req_type,
    input  logic [31:0]                     i_request_size,
    input  logic [31:0]                     i_align_bytes,
    input  logic [31:0]                     i_free_address,
    input  logic                            i_rsp_valid,
    input  logic                            i_rsp_ready,
    input  logic [31:0]                     i_result_address,
    input  logic [1:0]                      i_status,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_responses,
    output int                              o_splits,
    output int                              o_merges
);
    import ffba_pkg::*;

    typedef struct packed {
        logic [31:0] addr;
        logic [1:0]  status;
    } t_rsp;

    logic [31:0] heap_base, heap_length, split_margin;
    logic [7:0]  header_bytes;
    logic [31:0] seg_start [MAX_SEGMENTS];
    logic [31:0] seg_size  [MAX_SEGMENTS];
    logic        seg_used  [MAX_SEGMENTS];
    int          seg_count;
    t_rsp        expected_rsp_q [$];

    function automatic void rebuild_table();
        for (int k = 0; k < MAX_SEGMENTS; k++) begin
            seg_start[k] = '0;
            seg_size[k]  = '0;
            seg_used[k]  = 1'b0;
        end
        seg_start[0] = heap_base;
        seg_size[0]  = (heap_length > header_bytes) ? heap_length - header_bytes : '0;
        seg_count    = 1;
    endfunction

    function automatic void move_entry(int dst, int src);
        seg_start[dst] = seg_start[src];
        seg_size[dst]  = seg_size[src];
        seg_used[dst]  = seg_used[src];
    endfunction

    function automatic t_rsp predict_alloc(logic [31:0] size, logic [31:0] align);
        logic [33:0] need;
        logic [31:0] payload;
        t_rsp        r;
        int          i;
        need = {2'b0, size} + {2'b0, align};
        r.addr = '0;
        r.status = ST_OOM;
        i = 0;
        while (i < seg_count && !(!seg_used[i] && {2'b0, seg_size[i]} >= need)) i++;
        if (i >= seg_count) return r;
        if ({2'b0, seg_size[i]} > need + header_bytes + split_margin[15:0]
                && seg_count < MAX_SEGMENTS) begin
            for (int k = seg_count; k > i + 1; k--) move_entry(k, k - 1);
            seg_start[i+1] = seg_start[i] + header_bytes + need[31:0];
            seg_size[i+1]  = seg_size[i] - header_bytes - need[31:0];
            seg_used[i+1]  = 1'b0;
            seg_size[i]    = need[31:0];
            seg_count++;
            o_splits++;
        end
        payload = seg_start[i] + header_bytes;
        r.addr = (align != 0) ? ((payload + align) & (32'd0 - align)) : payload;
        seg_used[i] = 1'b1;
        r.status = ST_OK;
        return r;
    endfunction

    function automatic t_rsp predict_free(logic [31:0] addr);
        logic [32:0] lo, hi, total;
        t_rsp        r;
        int          i;
        r.addr = '0;
        r.status = ST_NOT_FOUND;
        for (i = 0; i < seg_count; i++) begin
            lo = {1'b0, seg_start[i] + header_bytes};
            hi = lo + seg_size[i];
            if ({1'b0, addr} >= lo && {1'b0, addr} <= hi) begin
                seg_used[i] = 1'b0;
                r.status = ST_OK;
                break;
            end
        end
        i = 0;
        while (i + 1 < seg_count) begin
            if (!seg_used[i] && !seg_used[i+1]) begin
                total = {1'b0, seg_size[i]} + seg_size[i+1] + header_bytes;
                seg_size[i] = total[32] ? 32'hFFFF_FFFF : total[31:0];
                for (int k = i + 1; k + 1 < seg_count; k++) move_entry(k, k + 1);
                seg_count--;
                o_merges++;
            end else begin
                i++;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp exp_r;
        if (!i_rst_n) begin
            heap_base    = RST_HEAP_BASE;
            heap_length  = RST_HEAP_LENGTH;
            header_bytes = RST_HEADER_BYTES;
            split_margin = {16'd0, RST_SPLIT_MARGIN};
            rebuild_table();
            expected_rsp_q.delete();
            o_errors = 0;
            o_responses = 0;
            o_splits = 0;
            o_merges = 0;
        end else begin
            if (i_cfg_we && i_cfg_index < CFG_NUM) begin
                case (i_cfg_index)
                    CFG_HEAP_BASE:    heap_base = i_cfg_data;
                    CFG_HEAP_LENGTH:  heap_length = i_cfg_data;
                    CFG_HEADER_BYTES: header_bytes = i_cfg_data[7:0];
                    default:          split_margin = {16'd0, i_cfg_data[15:0]};
                endcase
                rebuild_table();
            end
            if (i_rsp_valid && i_rsp_ready) begin
                o_responses++;
                if (expected_rsp_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected response addr=%h status=%0d",
                             $time, i_result_address, i_status);
                end else begin
                    exp_r = expected_rsp_q.pop_front();
                    if (exp_r.addr !== i_result_address) begin
                        o_errors++;
                        $display("%0t: address mismatch expected %h actual %h",
                                 $time, exp_r.addr, i_result_address);
                    end
                    if (exp_r.status !== i_status) begin
                        o_errors++;
                        $display("%0t: status mismatch expected %0d actual %0d",
                                 $time, exp_r.status, i_status);
                    end
                end
            end
            if (i_valid && i_ready_in)
                expected_rsp_q.push_back(i_req_type == REQ_FREE ?
                    predict_free(i_free_address) :
                    predict_alloc(i_request_size, i_align_bytes));
        end
        o_pending = expected_rsp_q.size();
    end
endmodule

// ----- verif/tb_first_fit_block_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator_unit
// Drives allocate and free requests into the allocator under several heap
// configurations and random idling; a separate checker predicts each response.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator_unit;
    import ffba_pkg::*;

    // Cycle limit for the whole run: it has to cover the walk and merge of
    // every request plus the receiver's stalls.
    localparam int CYCLE_LIMIT = 1_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic        req_type = REQ_ALLOC;
    logic [31:0] req_size = '0;
    logic [31:0] req_align = '0;
    logic [31:0] req_addr = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic [31:0] rsp_addr;
    logic [1:0]  rsp_status;

    int errors, pending, responses, splits, merges;
    int send_idle_pct = 16;
    int recv_idle_pct = 61;
    int hold_off_cycles = 0;
    int cycle_count = 0;
    int requests_sent = 0;
    int configs_done = 0;

    // Pointers handed out, kept so that later frees hit real payloads.
    logic [31:0] live_ptrs [$];
    logic [31:0] cur_base = '0;
    logic [31:0] cur_length = 32'd65536;

    always #1 i_clk = ~i_clk;

    first_fit_block_allocator_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .o_ready(req_ready),
        .i_req_type(req_type), .i_request_size(req_size),
        .i_align_bytes(req_align), .i_free_address(req_addr),
        .o_valid(rsp_valid), .i_ready(rsp_ready),
        .o_result_address(rsp_addr), .o_status(rsp_status)
    );

    ffba_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .i_ready_in(req_ready),
        .i_req_type(req_type), .i_request_size(req_size),
        .i_align_bytes(req_align), .i_free_address(req_addr),
        .i_rsp_valid(rsp_valid), .i_rsp_ready(rsp_ready),
        .i_result_address(rsp_addr), .i_status(rsp_status),
        .o_errors(errors), .o_pending(pending), .o_responses(responses),
        .o_splits(splits), .o_merges(merges)
    );

    // The receiver stalls at random, and during a hold-off it stays low for
    // the whole stretch so that the block backs up and stops taking requests.
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_ready <= 1'b0;
        end else begin
            rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // The watchdog ends the run if the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending);
            $display("FAILURE");
            $finish;
        end
    end

    // Offers one request and waits until it is accepted. A random idle gap
    // may come first, with valid low.
    task automatic send_request(logic kind, logic [31:0] size, logic [31:0] align,
                                logic [31:0] addr);
        while ($urandom_range(99, 0) < send_idle_pct) @(posedge i_clk);
        req_valid <= 1'b1;
        req_type  <= kind;
        req_size  <= size;
        req_align <= align;
        req_addr  <= addr;
        @(posedge i_clk);
        while (!req_ready) @(posedge i_clk);
        req_valid <= 1'b0;
        @(posedge i_clk);
        requests_sent++;
    endtask

    // Waits for every response, then lets the block sit idle for a while
    // before any register write.
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        configs_done++;
        if (idx == CFG_HEAP_BASE) cur_base = value;
        if (idx == CFG_HEAP_LENGTH) cur_length = value;
        live_ptrs.delete();
    endtask

    // A random free address: mostly a live pointer, sometimes nearby,
    // sometimes anywhere.
    function automatic logic [31:0] pick_free_address();
        int sel;
        sel = $urandom_range(99, 0);
        if (sel < 70 && live_ptrs.size() != 0)
            return live_ptrs[$urandom_range(live_ptrs.size() - 1, 0)];
        if (sel < 90)
            return cur_base + $urandom_range(cur_length > 0 ? 1 : 0, 0) *
                   ($urandom() % (cur_length == 0 ? 1 : cur_length));
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_align();
        int sel;
        sel = $urandom_range(99, 0);
        if (sel < 45) return '0;
        if (sel < 90) return 32'd1 << $urandom_range(8, 0);
        if (sel < 95) return 32'd1 << $urandom_range(31, 0);
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_size();
        int sel;
        sel = $urandom_range(99, 0);
        if (sel < 80) return $urandom_range(cur_length / 8 + 1, 0);
        if (sel < 95) return $urandom_range(4096, 0);
        return $urandom();
    endfunction

    task automatic random_phase(int count);
        logic [31:0] a;
        repeat (count) begin
            if ($urandom_range(99, 0) < 55) begin
                a = pick_size();
                send_request(REQ_ALLOC, a, pick_align(), $urandom());
                // Pointer bookkeeping is approximate; the payload start is
                // known only to the checker, so the free later hits with the
                // returned pointer whenever it lands in the payload.
                @(posedge i_clk);
                if (rsp_valid && rsp_ready && rsp_status == ST_OK)
                    live_ptrs.push_back(rsp_addr);
            end else begin
                send_request(REQ_FREE, $urandom(), $urandom(), pick_free_address());
            end
            if (live_ptrs.size() > 32) void'(live_ptrs.pop_front());
        end
    endtask

    // Grab pointers from the response port as they pass.
    always @(posedge i_clk)
        if (rsp_valid && rsp_ready && rsp_status == ST_OK && rsp_addr != 0)
            live_ptrs.push_back(rsp_addr);

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on the reset configuration: extremes of the fields,
        // both request kinds and the named corner cases.
        send_request(REQ_ALLOC, 32'd0, 32'd0, 32'd0);
        send_request(REQ_ALLOC, 32'd100, 32'd64, 32'hFFFF_FFFF);
        send_request(REQ_ALLOC, 32'd40, 32'd24, 32'd0);
        send_request(REQ_ALLOC, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_request(REQ_ALLOC, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd0);
        send_request(REQ_ALLOC, 32'd65000, 32'd0, 32'd0);
        send_request(REQ_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd16);
        send_request(REQ_FREE, 32'd0, 32'd0, 32'd16);
        send_request(REQ_FREE, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_request(REQ_FREE, 32'd0, 32'd0, 32'd0);
        for (int k = 0; k < 17; k++)
            send_request(REQ_ALLOC, 32'd8 + k, 32'd0, 32'd0);
        send_request(REQ_ALLOC, 32'd1, 32'd0, 32'd0);
        drain();

        // Heap shorter than a header, then a heap at the top of the address
        // space where payload addresses wrap.
        write_reg(CFG_HEAP_LENGTH, 32'd8);
        send_request(REQ_ALLOC, 32'd0, 32'd0, 32'd0);
        send_request(REQ_FREE, 32'd0, 32'd0, 32'd16);
        drain();
        write_reg(CFG_HEAP_BASE, 32'hFFFF_FF00);
        write_reg(CFG_HEAP_LENGTH, 32'hFFFF_FFFF);
        write_reg(CFG_HEADER_BYTES, 32'hFF);
        write_reg(CFG_SPLIT_MARGIN, 32'hFFFF);
        write_reg(8'd9, 32'h1234);
        send_request(REQ_ALLOC, 32'd300, 32'd16, 32'd0);
        send_request(REQ_ALLOC, 32'd0, 32'd0, 32'd0);
        send_request(REQ_FREE, 32'd0, 32'd0, 32'hFFFF_FFFF);
        drain();

        // Random phases through several settings and idling profiles.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase % 3)
                0: begin send_idle_pct = 16; recv_idle_pct = 61; end
                1: begin send_idle_pct = 61; recv_idle_pct = 16; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (phase)
                0: begin
                    write_reg(CFG_HEAP_BASE, 32'h1000);
                    write_reg(CFG_HEAP_LENGTH, 32'd4096);
                    write_reg(CFG_HEADER_BYTES, 32'd8);
                    write_reg(CFG_SPLIT_MARGIN, 32'd0);
                end
                1: begin
                    write_reg(CFG_HEADER_BYTES, 32'd0);
                    write_reg(CFG_SPLIT_MARGIN, 32'd4);
                end
                2: begin
                    write_reg(CFG_HEAP_BASE, $urandom());
                    write_reg(CFG_HEAP_LENGTH, $urandom_range(65536, 256));
                    write_reg(CFG_HEADER_BYTES, $urandom_range(255, 0));
                end
                3: write_reg(CFG_SPLIT_MARGIN, $urandom_range(512, 0));
                4: begin
                    write_reg(CFG_HEAP_BASE, 32'd0);
                    write_reg(CFG_HEAP_LENGTH, 32'd1024);
                    write_reg(CFG_HEADER_BYTES, 32'd16);
                    write_reg(CFG_SPLIT_MARGIN, 32'd16);
                end
                default: write_reg(CFG_HEAP_LENGTH, 32'd16384);
            endcase
            if (phase == 0) hold_off_cycles = 400;
            random_phase(310);
            drain();
        end

        $display("Run covered %0d requests over %0d register writes: %0d splits,",
                 requests_sent, configs_done, splits);
        $display("%0d merges and %0d responses checked.", merges, responses);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
